// ===== rtl/core/tmpb_pkg.sv =====
package tmpb_pkg;

  // parameter defaults
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int MAX_WINDOW_DEF  = 64;

  // fixed port widths
  localparam int IN_W       = 12;
  localparam int OUT_W      = 12;
  localparam int DUTY_W     = 8;
  localparam int CMP_W      = 12;
  localparam int BAR_W      = 6;
  localparam int COUNT_W    = 7;
  localparam int OFFSET_W   = 12;
  localparam int PERIOD_W   = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_COUNT = 2'd0,
    REG_LEVEL_OFFSET = 2'd1,
    REG_PWM_PERIOD   = 2'd2
  } cfg_reg_t;

  // configuration reset values
  localparam logic [COUNT_W-1:0]  SAMPLE_COUNT_RST = 7'd10;
  localparam logic [OFFSET_W-1:0] LEVEL_OFFSET_RST = 12'd2000;
  localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST   = 11'd512;

  // limits
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 11'd1024;
  localparam logic [OUT_W-1:0]    FILT_MAX   = 12'd4095;
  localparam int                  MIN_WINDOW = 3;

  // reciprocal constants: x/20 for x < 4096, y/100 for y < 2^19
  localparam logic [11:0] DUTY_RECIP = 12'd3277;
  localparam int          DUTY_SHIFT = 16;
  localparam logic [20:0] CMP_RECIP  = 21'd1342178;
  localparam int          CMP_SHIFT  = 27;

  // bar graph thresholds
  localparam int BAR_STEP = 400;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // derived widths
  function automatic int samp_w(input int sample_bits);
    return (sample_bits < IN_W) ? sample_bits : IN_W;
  endfunction

  function automatic int cnt_w(input int max_window);
    return $clog2(max_window + 1);
  endfunction

  function automatic int sum_w(input int sample_bits, input int max_window);
    return samp_w(sample_bits) + cnt_w(max_window);
  endfunction

  function automatic int div_w(input int max_window);
    return $clog2(max_window - 1);
  endfunction

  // thermometer mask, empty at or above six steps
  function automatic logic [BAR_W-1:0] bar_mask(input logic [OUT_W-1:0] lvl);
    logic [BAR_W-1:0] m;
    m = '0;
    for (int j = 0; j < BAR_W; j++) begin
      m[j] = (lvl >= OUT_W'(BAR_STEP * j)) && (lvl < OUT_W'(BAR_STEP * BAR_W));
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/tmpb_front.sv =====
module tmpb_front #(
  parameter int SAMPLE_BITS = tmpb_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_WINDOW  = tmpb_pkg::MAX_WINDOW_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               accept,
  input  logic [tmpb_pkg::IN_W-1:0]                          sample,
  input  logic [tmpb_pkg::COUNT_W-1:0]                       sample_count,
  output logic                                               push,
  output logic [tmpb_pkg::sum_w(SAMPLE_BITS, MAX_WINDOW)-1:0] trimmed,
  output logic [tmpb_pkg::div_w(MAX_WINDOW)-1:0]             divisor
);

  localparam int SAMP_W = tmpb_pkg::samp_w(SAMPLE_BITS);
  localparam int CNT_W  = tmpb_pkg::cnt_w(MAX_WINDOW);
  localparam int SUM_W  = tmpb_pkg::sum_w(SAMPLE_BITS, MAX_WINDOW);
  localparam int DIV_W  = tmpb_pkg::div_w(MAX_WINDOW);
  localparam int NW     = (CNT_W + 1 > tmpb_pkg::COUNT_W + 1) ? CNT_W + 1
                                                              : tmpb_pkg::COUNT_W + 1;

  logic [SUM_W-1:0]  running_sum;
  logic [SAMP_W-1:0] window_min;
  logic [SAMP_W-1:0] window_max;
  logic [CNT_W-1:0]  samples_seen;

  logic [SAMP_W-1:0] s;
  logic [SUM_W-1:0]  sum_next;
  logic [SAMP_W-1:0] min_next;
  logic [SAMP_W-1:0] max_next;
  logic [CNT_W:0]    seen_inc;
  logic [NW-1:0]     count_ext;
  logic [NW-1:0]     n_eff;
  logic [SUM_W-1:0]  extremes;
  logic              window_end;

  // fold the new sample into the window
  always_comb begin
    s        = sample[SAMP_W-1:0];
    sum_next = running_sum + SUM_W'(s);
    min_next = (s < window_min) ? s : window_min;
    max_next = (s > window_max) ? s : window_max;
    seen_inc = {1'b0, samples_seen} + (CNT_W + 1)'(1);
  end

  // effective window length, clamped to the legal range
  always_comb begin
    count_ext = NW'(sample_count);
    if (count_ext < NW'(tmpb_pkg::MIN_WINDOW)) begin
      n_eff = NW'(tmpb_pkg::MIN_WINDOW);
    end else if (count_ext > NW'(MAX_WINDOW)) begin
      n_eff = NW'(MAX_WINDOW);
    end else begin
      n_eff = count_ext;
    end
  end

  // window end: drop min and max, hand off sum and divisor
  always_comb begin
    window_end = NW'(seen_inc) >= n_eff;
    extremes   = SUM_W'(min_next) + SUM_W'(max_next);
    trimmed    = (sum_next >= extremes) ? (sum_next - extremes) : '0;
    divisor    = DIV_W'(n_eff - NW'(2));
    push       = accept && window_end;
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      window_min   <= '1;
      window_max   <= '0;
      samples_seen <= '0;
    end else if (accept) begin
      if (window_end) begin
        running_sum  <= '0;
        window_min   <= '1;
        window_max   <= '0;
        samples_seen <= '0;
      end else begin
        running_sum  <= sum_next;
        window_min   <= min_next;
        window_max   <= max_next;
        samples_seen <= seen_inc[CNT_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/tmpb_fifo.sv =====
module tmpb_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int DEPTH = tmpb_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  logic do_push;
  logic do_pop;

  always_comb begin
    full    = (fill == (PTR_W + 1)'(DEPTH));
    empty   = (fill == '0);
    do_push = push && !full;
    do_pop  = pop && !empty;
    rdata   = mem[rd_ptr];
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + (PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - (PTR_W + 1)'(1);
      end
    end
  end

endmodule

// ===== rtl/core/tmpb_back.sv =====
module tmpb_back #(
  parameter int SUM_W = 18,
  parameter int DIV_W = 6
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_empty,
  output logic                            q_pop,
  input  logic [SUM_W-1:0]                q_trimmed,
  input  logic [DIV_W-1:0]                q_divisor,
  input  logic [tmpb_pkg::OFFSET_W-1:0]   level_offset,
  input  logic [tmpb_pkg::PERIOD_W-1:0]   pwm_period,
  output logic                            done,
  output logic [tmpb_pkg::OUT_W-1:0]      filtered,
  output logic [tmpb_pkg::OUT_W-1:0]      level,
  output logic [tmpb_pkg::DUTY_W-1:0]     duty_percent,
  output logic [tmpb_pkg::CMP_W-1:0]      pwm_compare,
  output logic [tmpb_pkg::BAR_W-1:0]      led_bar
);

  localparam int OUT_W  = tmpb_pkg::OUT_W;
  localparam int DUTY_W = tmpb_pkg::DUTY_W;
  localparam int BIT_W  = (SUM_W > 1) ? $clog2(SUM_W) : 1;
  localparam int QW     = (SUM_W > OUT_W) ? SUM_W : OUT_W;
  localparam int DPROD_W = OUT_W + 12;
  localparam int CPROD_W = tmpb_pkg::PERIOD_W + DUTY_W;
  localparam int SPROD_W = CPROD_W + 21;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LEVEL,
    ST_DUTY,
    ST_CMP,
    ST_SCALE,
    ST_OUT
  } state_t;

  state_t state;

  logic [SUM_W-1:0]   quo;
  logic [DIV_W-1:0]   rem;
  logic [DIV_W-1:0]   div_r;
  logic [BIT_W-1:0]   bit_cnt;
  logic [OUT_W-1:0]   filt_r;
  logic [OUT_W-1:0]   level_r;
  logic [DPROD_W-1:0] duty_prod;
  logic [DUTY_W-1:0]  duty_r;
  logic [CPROD_W-1:0] cmp_prod;
  logic [SPROD_W-1:0] scale_prod;

  logic [DIV_W:0]     shifted;
  logic               fits;
  logic [DIV_W:0]     rem_sub;
  logic [QW-1:0]      quo_ext;
  logic [OUT_W-1:0]   filt_sat;
  logic [DUTY_W-1:0]  duty_c;
  logic [tmpb_pkg::PERIOD_W-1:0] period_eff;

  // one restoring division step, plus saturation and clamps
  always_comb begin
    shifted    = {rem, quo[SUM_W-1]};
    fits       = shifted >= {1'b0, div_r};
    rem_sub    = shifted - {1'b0, div_r};
    quo_ext    = QW'(quo);
    filt_sat   = (quo_ext > QW'(tmpb_pkg::FILT_MAX)) ? tmpb_pkg::FILT_MAX
                                                     : quo_ext[OUT_W-1:0];
    duty_c     = duty_prod[tmpb_pkg::DUTY_SHIFT +: DUTY_W];
    period_eff = (pwm_period > tmpb_pkg::PERIOD_MAX) ? tmpb_pkg::PERIOD_MAX : pwm_period;
    q_pop      = (state == ST_IDLE) && !q_empty;
  end

  // sequencer with registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            quo     <= q_trimmed;
            div_r   <= q_divisor;
            rem     <= '0;
            bit_cnt <= BIT_W'(SUM_W - 1);
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= fits ? rem_sub[DIV_W-1:0] : shifted[DIV_W-1:0];
          quo <= {quo[SUM_W-2:0], fits};
          if (bit_cnt == '0) begin
            state <= ST_LEVEL;
          end else begin
            bit_cnt <= bit_cnt - BIT_W'(1);
          end
        end
        ST_LEVEL: begin
          filt_r  <= filt_sat;
          level_r <= (filt_sat > level_offset) ? (filt_sat - level_offset) : '0;
          state   <= ST_DUTY;
        end
        ST_DUTY: begin
          duty_prod <= DPROD_W'(level_r) * DPROD_W'(tmpb_pkg::DUTY_RECIP);
          state     <= ST_CMP;
        end
        ST_CMP: begin
          duty_r   <= duty_c;
          cmp_prod <= CPROD_W'(period_eff) * CPROD_W'(duty_c);
          state    <= ST_SCALE;
        end
        ST_SCALE: begin
          scale_prod <= SPROD_W'(cmp_prod) * SPROD_W'(tmpb_pkg::CMP_RECIP);
          state      <= ST_OUT;
        end
        ST_OUT: begin
          done         <= 1'b1;
          filtered     <= filt_r;
          level        <= level_r;
          duty_percent <= duty_r;
          pwm_compare  <= scale_prod[tmpb_pkg::CMP_SHIFT +: tmpb_pkg::CMP_W];
          led_bar      <= tmpb_pkg::bar_mask(level_r);
          state        <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/trimmed_mean_pwm_bargraph.sv =====
// Trimmed-mean ADC filter with PWM duty and LED bar outputs. A sample is
// taken on each cycle with start high and busy low; busy rises only when the
// two-entry window queue is full. On the sample that closes a window the
// trimmed sum goes via that queue to a bit-serial divider that forms one bit
// per cycle, and once the divider is free the result appears with a one-cycle
// done pulse. The result ports hold their value until the next done, but the
// receiver cannot stall: each result must be taken in its done cycle.
// cfg_ready is always high; configuration writes take effect at once and
// belong to idle periods.
module trimmed_mean_pwm_bargraph #(
  parameter int SAMPLE_BITS = tmpb_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_WINDOW  = tmpb_pkg::MAX_WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [tmpb_pkg::IN_W-1:0]        sample,
  output logic                             done,
  output logic [tmpb_pkg::OUT_W-1:0]       filtered,
  output logic [tmpb_pkg::OUT_W-1:0]       level,
  output logic [tmpb_pkg::DUTY_W-1:0]      duty_percent,
  output logic [tmpb_pkg::CMP_W-1:0]       pwm_compare,
  output logic [tmpb_pkg::BAR_W-1:0]       led_bar,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tmpb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tmpb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SUM_W = tmpb_pkg::sum_w(SAMPLE_BITS, MAX_WINDOW);
  localparam int DIV_W = tmpb_pkg::div_w(MAX_WINDOW);
  localparam int Q_W   = SUM_W + DIV_W;

  logic [tmpb_pkg::COUNT_W-1:0]  sample_count;
  logic [tmpb_pkg::OFFSET_W-1:0] level_offset;
  logic [tmpb_pkg::PERIOD_W-1:0] pwm_period;

  logic             accept;
  logic             push;
  logic [SUM_W-1:0] f_trimmed;
  logic [DIV_W-1:0] f_divisor;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic [Q_W-1:0]   q_rdata;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;
  assign accept    = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= tmpb_pkg::SAMPLE_COUNT_RST;
      level_offset <= tmpb_pkg::LEVEL_OFFSET_RST;
      pwm_period   <= tmpb_pkg::PWM_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (tmpb_pkg::cfg_reg_t'(cfg_index))
        tmpb_pkg::REG_SAMPLE_COUNT: sample_count <= cfg_data[tmpb_pkg::COUNT_W-1:0];
        tmpb_pkg::REG_LEVEL_OFFSET: level_offset <= cfg_data[tmpb_pkg::OFFSET_W-1:0];
        tmpb_pkg::REG_PWM_PERIOD:   pwm_period   <= cfg_data[tmpb_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // window accumulation
  tmpb_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .sample       (sample),
    .sample_count (sample_count),
    .push         (push),
    .trimmed      (f_trimmed),
    .divisor      (f_divisor)
  );

  // finished windows waiting for the divider
  tmpb_fifo #(
    .WIDTH (Q_W)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({f_trimmed, f_divisor}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // division and output scaling
  tmpb_back #(
    .SUM_W (SUM_W),
    .DIV_W (DIV_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_trimmed    (q_rdata[Q_W-1:DIV_W]),
    .q_divisor    (q_rdata[DIV_W-1:0]),
    .level_offset (level_offset),
    .pwm_period   (pwm_period),
    .done         (done),
    .filtered     (filtered),
    .level        (level),
    .duty_percent (duty_percent),
    .pwm_compare  (pwm_compare),
    .led_bar      (led_bar)
  );

endmodule

// ===== rtl/core/tmpb_checker.sv =====
module tmpb_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             done,
  input logic [tmpb_pkg::OUT_W-1:0]       filtered,
  input logic [tmpb_pkg::OUT_W-1:0]       level,
  input logic [tmpb_pkg::BAR_W-1:0]       led_bar,
  input logic                             cfg_ready
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("done high after reset");

  // each result runs the full division and scaling sequence, so strobes never touch
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done high two cycles in a row");

  // level never exceeds the filtered value
  a_level_le: assert property (@(posedge clk) disable iff (rst)
    done |-> (level <= filtered))
    else $error("level above filtered");

  // bar is a thermometer filled from the bottom
  a_bar_therm: assert property (@(posedge clk) disable iff (rst)
    done |-> ((led_bar & tmpb_pkg::BAR_W'(led_bar + tmpb_pkg::BAR_W'(1))) == '0))
    else $error("led_bar not a thermometer");

  // config port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("cfg_ready low");

endmodule

bind trimmed_mean_pwm_bargraph tmpb_checker u_tmpb_checker (
  .clk       (clk),
  .rst       (rst),
  .done      (done),
  .filtered  (filtered),
  .level     (level),
  .led_bar   (led_bar),
  .cfg_ready (cfg_ready)
);

// ===== tb/tb_trimmed_mean_pwm_bargraph.sv =====
`timescale 1ns / 100ps

import tmpb_pkg::*;

// one window result as seen on the output ports
typedef struct {
  logic [OUT_W-1:0]  filtered;
  logic [OUT_W-1:0]  level;
  logic [DUTY_W-1:0] duty_percent;
  logic [CMP_W-1:0]  pwm_compare;
  logic [BAR_W-1:0]  led_bar;
} bar_result_t;

class window_scoreboard;
  // register copies
  int unsigned window_len_reg;
  int unsigned offset_reg;
  int unsigned period_reg;
  // window state
  int unsigned sum_acc;
  int unsigned min_seen;
  int unsigned max_seen;
  int unsigned seen;
  bar_result_t expected_levels[$];
  int errors;

  function new();
    window_len_reg = SAMPLE_COUNT_RST;
    offset_reg     = LEVEL_OFFSET_RST;
    period_reg     = PWM_PERIOD_RST;
    errors         = 0;
    clear_window();
  endfunction

  function void clear_window();
    sum_acc  = 0;
    min_seen = 4095;
    max_seen = 0;
    seen     = 0;
  endfunction

  function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SAMPLE_COUNT: window_len_reg = data[COUNT_W-1:0];
      REG_LEVEL_OFFSET: offset_reg = data[OFFSET_W-1:0];
      REG_PWM_PERIOD:   period_reg = data[PERIOD_W-1:0];
      default: ;
    endcase
  endfunction

  // accumulate one sample, predict the result when the window closes
  function void note_sample(logic [IN_W-1:0] s);
    int unsigned n, trimmed, filt, lvl, duty, period, cmp, k;
    bar_result_t r;
    n = window_len_reg;
    if (n < MIN_WINDOW) n = MIN_WINDOW;
    if (n > MAX_WINDOW_DEF) n = MAX_WINDOW_DEF;
    sum_acc += s;
    if (s < min_seen) min_seen = s;
    if (s > max_seen) max_seen = s;
    seen++;
    if (seen < n) return;

    // drop min and max, divide the rest
    trimmed = (sum_acc >= min_seen + max_seen) ? sum_acc - min_seen - max_seen : 0;
    filt = trimmed / (n - 2);
    if (filt > 4095) filt = 4095;
    lvl = (filt > offset_reg) ? filt - offset_reg : 0;
    duty = lvl / 20;
    period = (period_reg > PERIOD_MAX) ? PERIOD_MAX : period_reg;
    cmp = period * duty / 100;
    k = lvl / BAR_STEP;

    r.filtered     = filt[OUT_W-1:0];
    r.level        = lvl[OUT_W-1:0];
    r.duty_percent = duty[DUTY_W-1:0];
    r.pwm_compare  = cmp[CMP_W-1:0];
    r.led_bar      = (k <= 5) ? BAR_W'((1 << (k + 1)) - 1) : '0;
    expected_levels.push_back(r);
    clear_window();
  endfunction

  function void check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endfunction

  function void check_result(bar_result_t act);
    bar_result_t exp_r;
    if (expected_levels.size() == 0) begin
      $display("%0t: unexpected result, expected none actual filtered %0d level %0d",
               $time, act.filtered, act.level);
      errors++;
      return;
    end
    exp_r = expected_levels.pop_front();
    check_field("filtered", exp_r.filtered, act.filtered);
    check_field("level", exp_r.level, act.level);
    check_field("duty_percent", exp_r.duty_percent, act.duty_percent);
    check_field("pwm_compare", exp_r.pwm_compare, act.pwm_compare);
    check_field("led_bar", exp_r.led_bar, act.led_bar);
  endfunction
endclass

module tb_trimmed_mean_pwm_bargraph;

  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 550;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [IN_W-1:0]       sample;
  logic                  done;
  logic [OUT_W-1:0]      filtered;
  logic [OUT_W-1:0]      level;
  logic [DUTY_W-1:0]     duty_percent;
  logic [CMP_W-1:0]      pwm_compare;
  logic [BAR_W-1:0]      led_bar;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  window_scoreboard sb;
  int idle_cycles;

  trimmed_mean_pwm_bargraph uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .sample(sample),
    .done(done),
    .filtered(filtered),
    .level(level),
    .duty_percent(duty_percent),
    .pwm_compare(pwm_compare),
    .led_bar(led_bar),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result monitor
  always @(posedge clk) begin
    bar_result_t act;
    act.filtered     = filtered;
    act.level        = level;
    act.duty_percent = duty_percent;
    act.pwm_compare  = pwm_compare;
    act.led_bar      = led_bar;
    if (!rst && done) sb.check_result(act);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_sample(input logic [IN_W-1:0] s, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  = 1'b1;
    sample = s;
    do @(posedge clk); while (busy);
    sb.note_sample(s);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // stop feeding, wait for outstanding results and let the pipeline empty
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (sb.expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [IN_W-1:0] pick_sample(input int center);
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = 4095;
      2, 3, 4: v = $urandom_range(0, 4095);
      default: v = center + int'($urandom_range(0, 64)) - 32;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[IN_W-1:0];
  endfunction

  logic [IN_W-1:0] default_window [10] =
    '{12'd4095, 12'd0, 12'd2100, 12'd2200, 12'd2300, 12'd2400, 12'd2500, 12'd2600,
      12'd2700, 12'd2800};

  initial begin
    int random_items, count_raw, eff, windows, n_items, center, offset_val, period_raw;
    logic no_gaps;

    sb          = new();
    rst         = 1'b1;
    start       = 1'b0;
    sample      = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_SAMPLE_COUNT;
    cfg_data    = '0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // one window at reset settings
    foreach (default_window[i]) send_sample(default_window[i], $urandom_range(0, 16));
    drain_results();

    // length below range acts as three, full-scale and zero windows
    write_reg(REG_SAMPLE_COUNT, 12'd0);
    write_reg(REG_LEVEL_OFFSET, 12'd0);
    write_reg(REG_PWM_PERIOD, 12'd1024);
    repeat (3) send_sample(12'd4095, $urandom_range(0, 16));
    repeat (3) send_sample(12'd0, 0);
    drain_results();

    // offset above the mean clamps, zero period
    write_reg(REG_SAMPLE_COUNT, 12'd2);
    write_reg(REG_LEVEL_OFFSET, 12'd4095);
    write_reg(REG_PWM_PERIOD, 12'd0);
    send_sample(12'd1000, 0);
    send_sample(12'd3000, 3);
    send_sample(12'd2000, 0);
    drain_results();

    // period above range, length 1, level just under the empty bar
    write_reg(REG_SAMPLE_COUNT, 12'd1);
    write_reg(REG_LEVEL_OFFSET, 12'd0);
    write_reg(REG_PWM_PERIOD, 12'd2047);
    repeat (3) send_sample(12'd2399, $urandom_range(0, 4));
    drain_results();

    // length above range, then shortened mid-window; mean saturates
    write_reg(REG_SAMPLE_COUNT, 12'd127);
    repeat (5) send_sample(12'd4095, $urandom_range(0, 16));
    drain_results();
    write_reg(REG_SAMPLE_COUNT, 12'd3);
    send_sample(12'd4095, 0);
    drain_results();

    // random phases, each with fresh register settings
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1:    count_raw = $urandom_range(0, 2);
        2:       count_raw = $urandom_range(65, 127);
        3:       count_raw = 64;
        4:       count_raw = 3;
        default: count_raw = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 7))
        0:       offset_val = 0;
        1:       offset_val = 4095;
        default: offset_val = $urandom_range(0, 4095);
      endcase
      case ($urandom_range(0, 9))
        0:       period_raw = 0;
        1:       period_raw = 1;
        2:       period_raw = 1024;
        3:       period_raw = 2047;
        4:       period_raw = 1025;
        5:       period_raw = $urandom_range(1025, 2047);
        default: period_raw = $urandom_range(1, 1024);
      endcase
      // unused upper data bits carry noise
      write_reg(REG_SAMPLE_COUNT, {5'($urandom_range(0, 31)), 7'(count_raw)});
      write_reg(REG_LEVEL_OFFSET, 12'(offset_val));
      write_reg(REG_PWM_PERIOD, {1'($urandom_range(0, 1)), 11'(period_raw)});

      eff = (count_raw < MIN_WINDOW) ? MIN_WINDOW :
            (count_raw > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : count_raw;
      windows = (eff > 16) ? 1 : $urandom_range(1, 4);
      // leftover samples carry a partial window into the next setting
      n_items = eff * windows + $urandom_range(0, eff - 1);
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 0) begin
        center = offset_val + $urandom_range(0, 2600);
        if (center > 4095) center = 4095;
      end else begin
        center = $urandom_range(0, 4095);
      end

      repeat (n_items) send_sample(pick_sample(center), no_gaps ? 0 : $urandom_range(0, 16));
      random_items += n_items;
      drain_results();
    end

    if (sb.errors == 0 && sb.expected_levels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
